>>> rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the capsule gauge pixel color core.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while the asynchronous reset is active.
`define CGPC_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while the asynchronous reset is active.
`define CGPC_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/cgpc_pkg.sv
// ---------------------------------------------------------------------------
// cgpc_pkg
// Types, widths and register codes shared by the capsule gauge color core.
// ---------------------------------------------------------------------------
package cgpc_pkg;

	// Pixel coordinate widths.
	localparam int COLUMN_BITS = 10;
	localparam int ROW_BITS    = 8;

	// Register widths.
	localparam int LEVEL_BITS    = 7;
	localparam int WIDTH_BITS    = 10;
	localparam int HEIGHT_BITS   = 8;
	localparam int THICK_BITS    = 7;
	localparam int CFG_DATA_BITS = 10;
	localparam int CFG_IDX_BITS  = 2;

	// Coordinates widened so the range checks see every input bit.
	localparam int COL_EXT_BITS = (COLUMN_BITS > WIDTH_BITS) ? COLUMN_BITS : WIDTH_BITS;
	localparam int ROW_EXT_BITS = (ROW_BITS > HEIGHT_BITS) ? ROW_BITS : HEIGHT_BITS;

	// Geometry widths: end radius, signed offsets, squared distances.
	localparam int RAD_BITS   = HEIGHT_BITS - 1;
	localparam int COORD_BITS = RAD_BITS + 1;
	localparam int SQ_BITS    = 2 * COORD_BITS;

	// Color arithmetic.
	localparam int COLOR_BITS   = 8;
	localparam int VP_BITS      = 12;
	localparam int BASEP_BITS   = 24;
	localparam int TENTH_SHIFT  = 15;
	localparam int TENTH_MUL    = 3277;
	localparam int NUM_BITS     = 19;
	localparam int DEN_BITS     = 11;
	localparam int RCP_BITS     = 17;
	localparam int DIV_SHIFT    = 19;
	localparam int PROD_BITS    = NUM_BITS + RCP_BITS;
	localparam int HEIGHT_COUNT = 1 << HEIGHT_BITS;

	localparam logic [LEVEL_BITS-1:0] LEVEL_FULL = LEVEL_BITS'(100);
	localparam logic [LEVEL_BITS-1:0] LEVEL_HALF = LEVEL_BITS'(50);
	localparam logic [COLOR_BITS-1:0] COLOR_MAX  = '1;

	// Register reset values.
	localparam logic [LEVEL_BITS-1:0]  LEVEL_RST  = LEVEL_BITS'(100);
	localparam logic [WIDTH_BITS-1:0]  WIDTH_RST  = WIDTH_BITS'(200);
	localparam logic [HEIGHT_BITS-1:0] HEIGHT_RST = HEIGHT_BITS'(30);
	localparam logic [THICK_BITS-1:0]  THICK_RST  = THICK_BITS'(3);

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_LEVEL  = 2'd0,
		CFG_WIDTH  = 2'd1,
		CFG_HEIGHT = 2'd2,
		CFG_THICK  = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [COLUMN_BITS-1:0] column;
		logic [ROW_BITS-1:0]    row;
	} pixel_t;

	typedef struct packed {
		logic                  drawn;
		logic [COLOR_BITS-1:0] red;
		logic [COLOR_BITS-1:0] green;
		logic [COLOR_BITS-1:0] blue;
	} result_t;

	typedef struct packed {
		logic [LEVEL_BITS-1:0]  level;
		logic [WIDTH_BITS-1:0]  width;
		logic [HEIGHT_BITS-1:0] height;
		logic [THICK_BITS-1:0]  thick;
	} cfg_t;

	// Stage 1 word: decoded geometry and color operands.
	typedef struct packed {
		logic                         oor;
		logic                         in_cap;
		logic signed [COORD_BITS-1:0] px;
		logic signed [COORD_BITS-1:0] py;
		logic [RAD_BITS-1:0]          rad;
		logic signed [COORD_BITS-1:0] inner;
		logic                         strip_border;
		logic                         fill_ok;
		logic                         hi;
		logic [VP_BITS-1:0]           vp;
		logic [DEN_BITS-1:0]          cnum;
		logic [DEN_BITS-1:0]          den;
		logic [NUM_BITS-1:0]          bnum;
		logic [RCP_BITS-1:0]          rcp;
	} front_t;

	// Stage 3 word: region decision and dividends for the three divides.
	typedef struct packed {
		logic                border;
		logic                fill;
		logic [NUM_BITS-1:0] rnum;
		logic [NUM_BITS-1:0] gnum;
		logic [NUM_BITS-1:0] bnum;
		logic [RCP_BITS-1:0] rcp;
		logic [DEN_BITS-1:0] den;
	} shape_t;

endpackage

>>> rtl/core/cgpc_front.sv
// ---------------------------------------------------------------------------
// cgpc_front
// First pipeline stage: range check, region offsets and color operands.
// ---------------------------------------------------------------------------
module cgpc_front import cgpc_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   accept,
	input  pixel_t pixel,
	input  cfg_t   cfg,
	output logic   valid_s1,
	output front_t front_s1
);

	logic [RCP_BITS-1:0]          rcp_tab [HEIGHT_COUNT];
	logic [COL_EXT_BITS-1:0]      col_x;
	logic [ROW_EXT_BITS-1:0]      row_x;
	logic [WIDTH_BITS-1:0]        col;
	logic [HEIGHT_BITS-1:0]       row;
	logic [RAD_BITS-1:0]          rad;
	logic                         left;
	logic                         right;
	logic signed [WIDTH_BITS+1:0] wmr;
	logic signed [WIDTH_BITS+1:0] cx;
	logic signed [WIDTH_BITS+1:0] pxw;
	logic signed [HEIGHT_BITS:0]  pyw;
	logic signed [HEIGHT_BITS+1:0] hmt;
	logic [LEVEL_BITS-1:0]        lvl;
	logic [LEVEL_BITS-1:0]        v;
	logic [HEIGHT_BITS-1:0]       hmr;
	front_t                       nxt;

	// Reciprocal table floor(2^19 / (5*h)); the entry for h = 0 is never used.
	for (genvar g = 0; g < HEIGHT_COUNT; g++) begin : g_rcp
		localparam int RcpDen = (g == 0) ? 1 : 5 * g;
		localparam int RcpVal = (g == 0) ? 0 : (1 << DIV_SHIFT) / RcpDen;
		assign rcp_tab[g] = RCP_BITS'(RcpVal);
	end

	always_comb begin
		col_x = COL_EXT_BITS'(pixel.column);
		row_x = ROW_EXT_BITS'(pixel.row);
		col   = col_x[WIDTH_BITS-1:0];
		row   = row_x[HEIGHT_BITS-1:0];
		rad   = cfg.height[HEIGHT_BITS-1:1];

		left  = col < WIDTH_BITS'(rad);
		wmr   = $signed({2'b00, cfg.width}) - $signed((WIDTH_BITS+2)'(rad));
		right = $signed({2'b00, col}) > wmr;
		cx    = left ? $signed((WIDTH_BITS+2)'(rad)) : wmr;
		pxw   = $signed({2'b00, col}) - cx;
		pyw   = $signed({1'b0, row}) - $signed((HEIGHT_BITS+1)'(rad));
		hmt   = $signed({2'b00, cfg.height}) - $signed((HEIGHT_BITS+2)'(cfg.thick));

		lvl = (cfg.level > LEVEL_FULL) ? LEVEL_FULL : cfg.level;
		v   = (lvl > LEVEL_HALF) ? (LEVEL_FULL - lvl) : lvl;
		hmr = cfg.height - row;

		nxt.oor    = (col_x >= COL_EXT_BITS'(cfg.width)) ||
			(row_x >= ROW_EXT_BITS'(cfg.height));
		nxt.in_cap = left || right;
		nxt.px     = pxw[COORD_BITS-1:0];
		nxt.py     = pyw[COORD_BITS-1:0];
		nxt.rad    = rad;
		nxt.inner  = $signed({1'b0, rad}) - $signed(COORD_BITS'(cfg.thick));
		nxt.strip_border = (row < HEIGHT_BITS'(cfg.thick)) ||
			($signed({2'b00, row}) > hmt);
		nxt.fill_ok = (17'(col) * 17'd100) < (17'(lvl) * 17'(cfg.width));
		nxt.hi   = lvl > LEVEL_HALF;
		nxt.vp   = VP_BITS'(v) * VP_BITS'(51);
		nxt.den  = DEN_BITS'(cfg.height) * DEN_BITS'(5);
		nxt.cnum = DEN_BITS'(cfg.height) * DEN_BITS'(5) - DEN_BITS'({row, 2'b00});
		nxt.bnum = NUM_BITS'(hmr) * NUM_BITS'(500);
		nxt.rcp  = rcp_tab[cfg.height];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		front_s1 <= nxt;
	end

endmodule

>>> rtl/core/cgpc_shape.sv
// ---------------------------------------------------------------------------
// cgpc_shape
// Stages 2 and 3: squared distances, region decision and color dividends.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module cgpc_shape import cgpc_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   valid_s1,
	input  front_t front_s1,
	output logic   valid_s3,
	output shape_t shape_s3
);

	typedef struct packed {
		logic                  oor;
		logic                  in_cap;
		logic [SQ_BITS-1:0]    dsq;
		logic [SQ_BITS-1:0]    rr;
		logic [SQ_BITS-1:0]    ii;
		logic                  strip_border;
		logic                  fill_ok;
		logic                  hi;
		logic [COLOR_BITS-1:0] base;
		logic [DEN_BITS-1:0]   cnum;
		logic [DEN_BITS-1:0]   den;
		logic [NUM_BITS-1:0]   bnum;
		logic [RCP_BITS-1:0]   rcp;
	} dist_t;

	logic signed [SQ_BITS-1:0] pxx;
	logic signed [SQ_BITS-1:0] pyy;
	logic signed [SQ_BITS-1:0] iix;
	logic [BASEP_BITS-1:0]     basep;
	logic                      valid_s2;
	dist_t                     nxt2;
	dist_t                     dist_s2;
	logic                      in_ring;
	logic                      in_core;
	logic                      border;
	logic                      fill;
	logic [COLOR_BITS-1:0]     red;
	logic [COLOR_BITS-1:0]     green;
	shape_t                    nxt3;

	// Stage 2: squares and the base color (v*51/10 via a reciprocal multiply).
	always_comb begin
		pxx   = SQ_BITS'(front_s1.px) * SQ_BITS'(front_s1.px);
		pyy   = SQ_BITS'(front_s1.py) * SQ_BITS'(front_s1.py);
		iix   = SQ_BITS'(front_s1.inner) * SQ_BITS'(front_s1.inner);
		basep = BASEP_BITS'(front_s1.vp) * BASEP_BITS'(TENTH_MUL);

		nxt2.oor          = front_s1.oor;
		nxt2.in_cap       = front_s1.in_cap;
		nxt2.dsq          = $unsigned(pxx) + $unsigned(pyy);
		nxt2.rr           = SQ_BITS'(front_s1.rad) * SQ_BITS'(front_s1.rad);
		nxt2.ii           = $unsigned(iix);
		nxt2.strip_border = front_s1.strip_border;
		nxt2.fill_ok      = front_s1.fill_ok;
		nxt2.hi           = front_s1.hi;
		nxt2.base         = basep[TENTH_SHIFT+COLOR_BITS-1:TENTH_SHIFT];
		nxt2.cnum         = front_s1.cnum;
		nxt2.den          = front_s1.den;
		nxt2.bnum         = front_s1.bnum;
		nxt2.rcp          = front_s1.rcp;
	end

	// Stage 3: pick border or fill and scale the fill color numerators.
	// A thick border can push the inner radius past the outer one; the ring
	// test is then taken exactly as the comparisons fall.
	always_comb begin
		in_ring = (dist_s2.dsq <= dist_s2.rr) && (dist_s2.dsq > dist_s2.ii);
		in_core = (dist_s2.dsq <= dist_s2.rr) && (dist_s2.dsq <= dist_s2.ii);
		border  = dist_s2.in_cap ? in_ring : dist_s2.strip_border;
		fill    = dist_s2.in_cap ? in_core : !dist_s2.strip_border;
		red     = dist_s2.hi ? dist_s2.base : COLOR_MAX;
		green   = dist_s2.hi ? COLOR_MAX : dist_s2.base;

		nxt3.border = !dist_s2.oor && border;
		nxt3.fill   = !dist_s2.oor && !border && fill && dist_s2.fill_ok;
		nxt3.rnum   = NUM_BITS'(red) * NUM_BITS'(dist_s2.cnum);
		nxt3.gnum   = NUM_BITS'(green) * NUM_BITS'(dist_s2.cnum);
		nxt3.bnum   = dist_s2.bnum;
		nxt3.rcp    = dist_s2.rcp;
		nxt3.den    = dist_s2.den;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		dist_s2  <= nxt2;
		shape_s3 <= nxt3;
	end

	`CGPC_ASSERT_IMP(a_region_excl, clk, arst_n, valid_s3,
		!(shape_s3.border && shape_s3.fill), "pixel marked both border and fill")

endmodule

>>> rtl/core/cgpc_div.sv
// ---------------------------------------------------------------------------
// cgpc_div
// Two-step divide by 5*h: reciprocal multiply, then one remainder correction.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module cgpc_div import cgpc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [NUM_BITS-1:0]   num,
	input  logic [RCP_BITS-1:0]   rcp,
	input  logic [DEN_BITS-1:0]   den,
	output logic [COLOR_BITS-1:0] quo
);

	logic [PROD_BITS-1:0]  prod;
	logic [COLOR_BITS-1:0] est_s4;
	logic [NUM_BITS-1:0]   num_s4;
	logic [DEN_BITS-1:0]   den_s4;
	logic [NUM_BITS-1:0]   rem;

	// The estimate never exceeds the true quotient and falls short by at most one.
	assign prod = PROD_BITS'(num) * PROD_BITS'(rcp);

	always_ff @(posedge clk) begin
		est_s4 <= prod[DIV_SHIFT+COLOR_BITS-1:DIV_SHIFT];
		num_s4 <= num;
		den_s4 <= den;
	end

	always_comb begin
		rem = num_s4 - NUM_BITS'(est_s4) * NUM_BITS'(den_s4);
		quo = est_s4 + COLOR_BITS'(rem >= NUM_BITS'(den_s4));
	end

	`CGPC_ASSERT_IMP(a_est_close, clk, arst_n,
		(den_s4 != '0) && (num_s4 < NUM_BITS'({den_s4, 8'h00})),
		rem < NUM_BITS'({den_s4, 1'b0}), "reciprocal estimate off by more than one")

endmodule

>>> rtl/core/capsule_gauge_pixel_color.sv
// ---------------------------------------------------------------------------
// capsule_gauge_pixel_color
// Paints one pixel of a capsule-shaped level gauge: border, fill or nothing.
// ---------------------------------------------------------------------------
// Usage: drive a pixel word (column, row relative to the gauge's top left
// corner) with start high. The word is taken at every rising edge where start
// is high and busy is low. busy is high only from reset until the first edge
// after reset is released; from then on a new word is taken every cycle.
// Each word gives exactly one result word. done is high for one cycle while
// result carries it; result is valid only in that cycle. Words come back in
// order, and one word per clock is sustained. The pipeline has five register
// stages: decode, squared distances, region decision with color numerators,
// reciprocal multiply of the three divides, and the remainder correction
// feeding the output register.
// The receiver cannot stall, so nothing is ever held back.
// Configuration: cfg_we writes cfg_data to register cfg_index (level, width,
// height, border thickness) at the edge; write only while no word is in flight.
// Reset clears the pipeline valid bits and loads the register defaults.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module capsule_gauge_pixel_color import cgpc_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  pixel_t                   pixel,
	output logic                     done,
	output result_t                  result,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data
);

	cfg_t                  cfg_q;
	logic                  ready_q;
	logic                  accept;
	logic                  valid_s1;
	front_t                front_s1;
	logic                  valid_s3;
	shape_t                shape_s3;
	logic                  valid_s4;
	logic                  border_s4;
	logic                  fill_s4;
	logic [COLOR_BITS-1:0] red_q;
	logic [COLOR_BITS-1:0] green_q;
	logic [COLOR_BITS-1:0] gray_q;
	logic                  valid_s5;
	result_t               result_s5;
	result_t               nxt_result;

	// Configuration registers. Writes land at the edge with no handshake.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.level  <= LEVEL_RST;
			cfg_q.width  <= WIDTH_RST;
			cfg_q.height <= HEIGHT_RST;
			cfg_q.thick  <= THICK_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				CFG_LEVEL:  cfg_q.level  <= cfg_data[LEVEL_BITS-1:0];
				CFG_WIDTH:  cfg_q.width  <= cfg_data[WIDTH_BITS-1:0];
				CFG_HEIGHT: cfg_q.height <= cfg_data[HEIGHT_BITS-1:0];
				CFG_THICK:  cfg_q.thick  <= cfg_data[THICK_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	// The pipeline never stalls; busy is only high during reset and up to the first edge after its release.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ready_q <= 1'b0;
		end else begin
			ready_q <= 1'b1;
		end
	end

	assign busy   = !ready_q;
	assign accept = start && ready_q;

	cgpc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.pixel    (pixel),
		.cfg      (cfg_q),
		.valid_s1 (valid_s1),
		.front_s1 (front_s1)
	);

	cgpc_shape u_shape (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.front_s1 (front_s1),
		.valid_s3 (valid_s3),
		.shape_s3 (shape_s3)
	);

	// Three dividers by 5*h run side by side: the two fill channels scaled by
	// (5h - 4row), and the gray level 500*(h - row), which equals 100*(h-row)/h.
	cgpc_div u_div_red (
		.clk    (clk),
		.arst_n (arst_n),
		.num    (shape_s3.rnum),
		.rcp    (shape_s3.rcp),
		.den    (shape_s3.den),
		.quo    (red_q)
	);

	cgpc_div u_div_green (
		.clk    (clk),
		.arst_n (arst_n),
		.num    (shape_s3.gnum),
		.rcp    (shape_s3.rcp),
		.den    (shape_s3.den),
		.quo    (green_q)
	);

	cgpc_div u_div_gray (
		.clk    (clk),
		.arst_n (arst_n),
		.num    (shape_s3.bnum),
		.rcp    (shape_s3.rcp),
		.den    (shape_s3.den),
		.quo    (gray_q)
	);

	// Region flags travel alongside the dividers' first stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		border_s4 <= shape_s3.border;
		fill_s4   <= shape_s3.fill;
	end

	// Border is gray in all three channels; fill has no blue; an undrawn pixel
	// reads as all zeros.
	always_comb begin
		nxt_result.drawn = border_s4 || fill_s4;
		if (border_s4) begin
			nxt_result.red   = gray_q;
			nxt_result.green = gray_q;
			nxt_result.blue  = gray_q;
		end else if (fill_s4) begin
			nxt_result.red   = red_q;
			nxt_result.green = green_q;
			nxt_result.blue  = '0;
		end else begin
			nxt_result.red   = '0;
			nxt_result.green = '0;
			nxt_result.blue  = '0;
		end
	end

	always_ff @(posedge clk) begin
		result_s5 <= nxt_result;
	end

	assign done   = valid_s5;
	assign result = result_s5;

	`CGPC_ASSERT_IMP(a_latency, clk, arst_n, done, $past(start && !busy, 5),
		"result word without a pixel word five edges earlier")
	`CGPC_ASSERT_NXT(a_border_gray, clk, arst_n, valid_s4 && border_s4,
		done && result.drawn && (result.red == result.blue) &&
		(result.green == result.blue), "border pixel is not gray")
	`CGPC_ASSERT_IMP(a_blank_black, clk, arst_n, done && !result.drawn,
		(result.red == '0) && (result.green == '0) && (result.blue == '0),
		"undrawn pixel carries a color")

endmodule

>>> tb/sv/capsule_gauge_pixel_color_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// capsule_gauge_pixel_color_tb
// Self-checking bench for the capsule gauge pixel color core. A queue-fed
// driver sends pixel words, a monitor compares every result word with a
// prediction made at the moment the pixel word was taken, under directed and
// randomized gauge settings.
// ---------------------------------------------------------------------------
module capsule_gauge_pixel_color_tb import cgpc_pkg::*;;

	logic                     clk;
	logic                     arst_n    = 1'b0;
	logic                     start     = 1'b0;
	logic                     busy;
	pixel_t                   pixel     = '0;
	logic                     done;
	result_t                  result;
	logic                     cfg_we    = 1'b0;
	logic [CFG_IDX_BITS-1:0]  cfg_index = CFG_LEVEL;
	logic [CFG_DATA_BITS-1:0] cfg_data  = '0;

	capsule_gauge_pixel_color uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.pixel     (pixel),
		.done      (done),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Our own copy of the gauge registers. They start at the reset defaults and
	// are updated by set_gauge, which only runs while nothing is in flight.
	int gauge_lvl = 100;
	int gauge_w   = 200;
	int gauge_h   = 30;
	int gauge_t   = 3;

	pixel_t  pixel_backlog[$];     // pixel words not yet taken by the core
	result_t predicted_colors[$];  // one predicted result word per taken pixel
	int      gap_pct        = 0;   // chance in percent that the driver idles
	int      words_sent     = 0;
	int      words_checked  = 0;
	int      mismatch_count = 0;
	int      gauge_settings = 1;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Computes the painted color of one pixel under the current gauge
	// registers. The ends are half circles of radius H/2; a pixel there is
	// border if its squared distance from the circle center lies between the
	// inner and outer squared radii. In the middle strip the top T rows and
	// the bottom T-1 rows are border. Everything else that lies inside may be fill, which
	// only shows left of the level.
	function automatic result_t paint_pixel(pixel_t px_in);
		int      col, row, lvl, rad, cx, dx, dy, dsq, inner, num, den, base_r, base_g;
		int      gray;
		logic    is_border, is_fill;
		result_t res;
		col       = px_in.column;
		row       = px_in.row;
		lvl       = (gauge_lvl > 100) ? 100 : gauge_lvl;
		rad       = gauge_h / 2;
		res       = '0;
		is_border = 1'b0;
		is_fill   = 1'b0;
		// Anything past the gauge box, and every pixel of a zero-size gauge,
		// stays untouched.
		if (col >= gauge_w || row >= gauge_h)
			return res;
		if (col < rad || col > gauge_w - rad) begin
			cx    = (col < rad) ? rad : gauge_w - rad;
			dx    = col - cx;
			dy    = row - rad;
			dsq   = dx * dx + dy * dy;
			// A border thicker than the radius makes inner negative; its square
			// is still used as is, which can leave the whole end filled.
			inner = rad - gauge_t;
			if (dsq <= rad * rad) begin
				if (dsq > inner * inner)
					is_border = 1'b1;
				else
					is_fill = 1'b1;
			end
		end else if (row < gauge_t || row > gauge_h - gauge_t) begin
			is_border = 1'b1;
		end else begin
			is_fill = 1'b1;
		end
		if (is_border) begin
			gray      = 100 * (gauge_h - row) / gauge_h;
			res.drawn = 1'b1;
			res.red   = COLOR_BITS'(gray);
			res.green = COLOR_BITS'(gray);
			res.blue  = COLOR_BITS'(gray);
		end else if (is_fill && col * 100 < lvl * gauge_w) begin
			// Red to green with the level, darkened toward the bottom rows.
			if (lvl > 50) begin
				base_r = (100 - lvl) * 510 / 100;
				base_g = 255;
			end else begin
				base_r = 255;
				base_g = lvl * 510 / 100;
			end
			num       = 5 * gauge_h - 4 * row;
			den       = 5 * gauge_h;
			res.drawn = 1'b1;
			res.red   = COLOR_BITS'(base_r * num / den);
			res.green = COLOR_BITS'(base_g * num / den);
		end
		return res;
	endfunction

	task automatic write_reg(input cfg_reg_t idx, input int value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= CFG_DATA_BITS'(value);
	endtask

	// Writes all four gauge registers back to back and mirrors them locally.
	task automatic set_gauge(input int lvl, input int wid, input int hgt, input int thk);
		write_reg(CFG_LEVEL, lvl);
		write_reg(CFG_WIDTH, wid);
		write_reg(CFG_HEIGHT, hgt);
		write_reg(CFG_THICK, thk);
		@(posedge clk);
		cfg_we <= 1'b0;
		gauge_lvl = lvl & 8'h7f;
		gauge_w   = wid & 10'h3ff;
		gauge_h   = hgt & 8'hff;
		gauge_t   = thk & 8'h7f;
		gauge_settings++;
		repeat (2) @(posedge clk);
	endtask

	task automatic push_pixel(input int col, input int row);
		pixel_t p;
		p.column = COLUMN_BITS'(col);
		p.row    = ROW_BITS'(row);
		pixel_backlog.push_back(p);
	endtask

	// Waits until every queued pixel word has been taken and every predicted
	// word has come back, then lets the pipeline settle before the registers
	// may change.
	task automatic drain();
		int n;
		n = 0;
		while ((pixel_backlog.size() != 0 || predicted_colors.size() != 0) && n < 20000) begin
			@(posedge clk);
			n++;
		end
		if (n >= 20000) begin
			$display("Drain stalled: %0d pixel words unsent, %0d results missing",
				pixel_backlog.size(), predicted_colors.size());
			mismatch_count++;
		end
		repeat (8) @(posedge clk);
	endtask

	// Driver: a word is taken at an edge where start is high and busy is low.
	// The prediction is made right there, so it always sees the registers that
	// the core used. A word that is held off by busy stays on the port.
	always @(posedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
			pixel <= '0;
		end else begin
			if (start && !busy) begin
				predicted_colors.push_back(paint_pixel(pixel));
				void'(pixel_backlog.pop_front());
				words_sent++;
			end
			if (!(start && busy)) begin
				if (pixel_backlog.size() != 0 && $urandom_range(99) >= gap_pct) begin
					start <= 1'b1;
					pixel <= pixel_backlog[0];
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Monitor: done marks a result word for exactly one cycle; it is compared
	// field by field with the oldest prediction.
	always @(posedge clk) begin
		result_t want;
		if (arst_n && done) begin
			if (predicted_colors.size() == 0) begin
				if (mismatch_count < 10)
					$display("Unexpected result word %p with nothing predicted", result);
				mismatch_count++;
			end else begin
				want = predicted_colors.pop_front();
				words_checked++;
				if (result.drawn !== want.drawn || result.red !== want.red ||
				    result.green !== want.green || result.blue !== want.blue) begin
					if (mismatch_count < 10)
						$display("Mismatch on word %0d: expected %p, got %p",
							words_checked, want, result);
					mismatch_count++;
				end
			end
		end
	end

	// Stimulus and end of run.
	initial begin
		int next_level, next_width, next_height, next_thick;
		int col, row, rad, lo;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Reset defaults: corners, strip fill and border, both ends, both
		// outside edges, the largest coordinates and the last row.
		push_pixel(0, 0);
		push_pixel(100, 15);
		push_pixel(100, 1);
		push_pixel(1, 15);
		push_pixel(15, 15);
		push_pixel(199, 15);
		push_pixel(200, 15);
		push_pixel(100, 30);
		push_pixel(1023, 255);
		push_pixel(100, 29);
		push_pixel(199, 0);
		drain();

		// Largest gauge with a level above 100, which acts as full.
		set_gauge(127, 1023, 255, 127);
		push_pixel(0, 127);
		push_pixel(1022, 254);
		push_pixel(1023, 0);
		push_pixel(500, 0);
		push_pixel(511, 127);
		drain();

		// Border thicker than the radius: the ends test against a negative
		// inner radius, the strip is border throughout.
		set_gauge(51, 100, 40, 60);
		push_pixel(5, 20);
		push_pixel(50, 20);
		push_pixel(99, 20);
		drain();

		// Zero-size gauge paints nothing.
		set_gauge(0, 0, 0, 0);
		push_pixel(0, 0);
		drain();

		// Smallest real gauge at exactly half level.
		set_gauge(50, 2, 2, 0);
		push_pixel(0, 0);
		push_pixel(1, 1);
		push_pixel(0, 1);
		drain();

		// Random part: fifteen gauge settings of seventy pixels each. The
		// driver idles often in the first five, more often in the next five,
		// and never in the last five.
		for (int batch = 0; batch < 15; batch++) begin
			gap_pct = (batch < 5) ? 28 : (batch < 10) ? 65 : 0;
			case ($urandom_range(7))
				0: next_level = 0;
				1: next_level = 50;
				2: next_level = 51;
				3: next_level = 100;
				4: next_level = $urandom_range(127, 101);
				default: next_level = $urandom_range(100);
			endcase
			case ($urandom_range(15))
				0: next_width = 0;
				1: next_width = 1;
				2: next_width = 2;
				3: next_width = 1023;
				default: next_width = $urandom_range(400, 3);
			endcase
			case ($urandom_range(15))
				0: next_height = 0;
				1: next_height = 1;
				2: next_height = 2;
				3: next_height = 255;
				default: next_height = $urandom_range(120, 3);
			endcase
			case ($urandom_range(7))
				0: next_thick = 0;
				1: next_thick = 127;
				2: next_thick = next_height / 2;
				3: next_thick = $urandom_range(127);
				default: next_thick = $urandom_range(10);
			endcase
			set_gauge(next_level, next_width, next_height, next_thick);
			rad = next_height / 2;
			for (int k = 0; k < 70; k++) begin
				row = $urandom_range(next_height);
				case ($urandom_range(9))
					0: begin
						col = $urandom_range(1023);
						row = $urandom_range(255);
					end
					1, 2: col = $urandom_range(rad + 1);
					3, 4: begin
						lo  = next_width - rad - 2;
						col = $urandom_range(next_width, (lo < 0) ? 0 : lo);
					end
					default: col = $urandom_range(next_width);
				endcase
				push_pixel(col, row);
			end
			drain();
		end

		repeat (20) @(posedge clk);
		if (predicted_colors.size() != 0) begin
			$display("%0d predicted result words never arrived", predicted_colors.size());
			mismatch_count++;
		end
		$display("Sent %0d pixel words under %0d gauge settings, %0d result words checked,",
			words_sent, gauge_settings, words_checked);
		$display("%0d mismatches.", mismatch_count);
		if (mismatch_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// Watchdog: far beyond the slowest correct run.
	initial begin
		#2000000;
		$display("Timeout with %0d pixel words unsent", pixel_backlog.size());
		$display("Regression FAIL");
		$finish;
	end

endmodule
